>>> src/lbof_pkg.sv
// ----------------------------------------------------------------------------
// lbof_pkg
// shared types, class codes and the pair action rom of the line break finder
// ----------------------------------------------------------------------------
package lbof_pkg;

	localparam int NUM_TBL_CLS = 27;

	localparam logic [4:0] CLS_AL        = 5'd12;
	localparam logic [4:0] CLS_WJ        = 5'd21;
	localparam logic [4:0] CLS_MANDATORY = 5'd27;
	localparam logic [4:0] CLS_SPACE     = 5'd28;

	localparam logic [20:0] CP_LF  = 21'h00000A;
	localparam logic [20:0] CP_LSEP = 21'h002028;
	localparam logic [20:0] CP_PSEP = 21'h002029;

	// pair actions: direct, indirect, prohibited, combining, combining after OP
	typedef enum logic [2:0] {PD, PI, PP, PC, PX} act_t;

	// classified item passed from the front to the back
	typedef struct packed {
		logic       sep;
		logic       space;
		logic       eot;
		logic [4:0] cls;
	} item_t;

	localparam act_t PAIR_ROM [NUM_TBL_CLS][NUM_TBL_CLS] = '{
		'{PP,PP,PP,PP,PP,PP,PP,PP,PP,PP,PP,PP,PP,PP,
		  PP,PP,PP,PP,PP,PP,PX,PP,PP,PP,PP,PP,PP},
		'{PD,PP,PP,PI,PI,PP,PP,PP,PP,PI,PI,PD,PD,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PP,PP,PP,PP,PI,PI,PI,PI,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PP,PP,PP,PI,PI,PI,PP,PP,PP,PI,PI,PI,PI,PI,
		  PI,PI,PI,PI,PI,PP,PC,PP,PI,PI,PI,PI,PI},
		'{PI,PP,PP,PI,PI,PI,PP,PP,PP,PI,PI,PI,PI,PI,
		  PI,PI,PI,PI,PI,PP,PC,PP,PI,PI,PI,PI,PI},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PD,PD,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PD,PD,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PI,PD,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PI,PI,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PI,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PI,PI,PI,
		  PD,PI,PI,PD,PD,PP,PC,PP,PI,PI,PI,PI,PI},
		'{PI,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PI,PI,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PI,PI,PI,PI,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PI,PI,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PI,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PD,PI,PP,PP,PP,PD,PD,PI,PD,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PD,PI,PP,PP,PP,PD,PD,PD,PD,PD,
		  PD,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PI,PP,PP,PI,PI,PI,PP,PP,PP,PI,PI,PI,PI,PI,
		  PI,PI,PI,PI,PI,PP,PC,PP,PI,PI,PI,PI,PI},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PD,PD,PD,
		  PD,PI,PI,PD,PP,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PD,PD,PD,PD,PD,PD,PD,PD,PD,PD,PD,PD,PD,PD,
		  PD,PD,PD,PD,PD,PP,PD,PD,PD,PD,PD,PD,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PD,PI,PI,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PD},
		'{PI,PP,PP,PI,PI,PI,PP,PP,PP,PI,PI,PI,PI,PI,
		  PI,PI,PI,PI,PI,PP,PC,PP,PI,PI,PI,PI,PI},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PI,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PI,PI},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PI,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PI},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PI,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PI,PI,PI,PI,PD},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PI,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PI,PI},
		'{PD,PP,PP,PI,PI,PI,PP,PP,PP,PD,PI,PD,PD,PD,
		  PI,PI,PI,PD,PD,PP,PC,PP,PD,PD,PD,PD,PI}
	};

	// pair lookup; codes outside the table never reach here in use
	function automatic act_t pair_lookup(input logic [4:0] b, input logic [4:0] c);
		act_t a;
		a = PD;
		if (b < CLS_MANDATORY && c < CLS_MANDATORY) begin
			a = PAIR_ROM[b][c];
		end
		return a;
	endfunction

endpackage

>>> src/lbof_front.sv
// ----------------------------------------------------------------------------
// lbof_front
// accepts characters, detects separators and spaces, remaps the class
// ----------------------------------------------------------------------------
module lbof_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [20:0]         code_point,
	input  logic [4:0]          break_class,
	input  logic                end_of_text,
	output logic                item_valid,
	input  logic                item_ready,
	output lbof_pkg::item_t     item
);

	logic            v_s1;
	lbof_pkg::item_t item_s1;
	lbof_pkg::item_t cls_item;

	always_comb begin
		cls_item.sep   = (code_point == lbof_pkg::CP_LF) || (code_point == lbof_pkg::CP_LSEP)
			|| (code_point == lbof_pkg::CP_PSEP) || (break_class == lbof_pkg::CLS_MANDATORY);
		cls_item.space = (break_class == lbof_pkg::CLS_SPACE);
		cls_item.eot   = end_of_text;
		// space opens a line as word joiner, other non-table classes as alphabetic
		if (break_class == lbof_pkg::CLS_SPACE) begin
			cls_item.cls = lbof_pkg::CLS_WJ;
		end else if (break_class >= lbof_pkg::CLS_MANDATORY) begin
			cls_item.cls = lbof_pkg::CLS_AL;
		end else begin
			cls_item.cls = break_class;
		end
	end

	assign in_ready   = !v_s1 || item_ready;
	assign item_valid = v_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls_item;
		end
	end

endmodule

>>> src/lbof_queue.sv
// ----------------------------------------------------------------------------
// lbof_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module lbof_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  lbof_pkg::item_t     wr_item,
	output logic                rd_valid,
	input  logic                rd_ready,
	output lbof_pkg::item_t     rd_item
);

	lbof_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> src/lbof_back.sv
// ----------------------------------------------------------------------------
// lbof_back
// line state, pair table lookup and the registered break result
// ----------------------------------------------------------------------------
module lbof_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  lbof_pkg::item_t     item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                break_before,
	output logic                break_after
);

	logic           at_line_start_q;
	logic [4:0]     base_class_q;
	logic           prev_was_space_q;
	logic           out_valid_q;
	logic           before_q;
	logic           after_q;

	logic           als_n;
	logic [4:0]     base_n;
	logic           pws_n;
	logic           before_n;
	logic           after_n;
	logic           take;
	lbof_pkg::act_t act;

	assign item_ready   = !out_valid_q || out_ready;
	assign take         = item_valid && item_ready;
	assign out_valid    = out_valid_q;
	assign break_before = before_q;
	assign break_after  = after_q;
	assign act          = lbof_pkg::pair_lookup(base_class_q, item.cls);

	always_comb begin
		als_n    = at_line_start_q;
		base_n   = base_class_q;
		pws_n    = prev_was_space_q;
		before_n = 1'b0;
		after_n  = 1'b0;
		if (at_line_start_q) begin
			als_n   = 1'b0;
			pws_n   = 1'b0;
			base_n  = item.cls;
			after_n = item.sep;
		end else if (item.sep) begin
			after_n = 1'b1;
		end else if (item.space) begin
			pws_n = 1'b1;
		end else begin
			unique case (act)
				lbof_pkg::PD, lbof_pkg::PI: begin
					if (act == lbof_pkg::PD || prev_was_space_q) begin
						before_n = 1'b1;
						als_n    = 1'b0;
						base_n   = item.cls;
					end else begin
						base_n = item.cls;
					end
					pws_n = 1'b0;
				end
				lbof_pkg::PC, lbof_pkg::PX: begin
					// combining keeps the base unless it follows a space
					if (prev_was_space_q) begin
						base_n = item.cls;
					end
					pws_n = 1'b0;
				end
				default: begin
					base_n = item.cls;
					pws_n  = 1'b0;
				end
			endcase
		end
		if (item.eot) begin
			after_n = 1'b1;
		end
		if (after_n) begin
			als_n = 1'b1;
			pws_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q  <= 1'b1;
			base_class_q     <= 5'd0;
			prev_was_space_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
			if (take) begin
				at_line_start_q  <= als_n;
				base_class_q     <= base_n;
				prev_was_space_q <= pws_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			before_q <= before_n;
			after_q  <= after_n;
		end
	end

endmodule

>>> src/line_break_opportunity_finder.sv
// ----------------------------------------------------------------------------
// line_break_opportunity_finder
// finds line break opportunities in a character stream, one result per item
// ----------------------------------------------------------------------------
// Each input item is one character (code point, precomputed line-break class,
// end-of-text flag); each result item says whether a line ends before and/or
// after that character. The block sustains one item per clock cycle while out_ready
// stays high; the rate is set by the back stage, where the pair rom lookup and the
// update of the base class, the space flag and the line-start flag are combinational
// and feed the state registers directly. From input accept to result valid an item
// passes the front register, the queue and the output register, in that order.
// No reset sweep is needed.
// ----------------------------------------------------------------------------
module line_break_opportunity_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [20:0] code_point,
	input  logic [4:0]  break_class,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        break_before,
	output logic        break_after
);

	// front to queue
	logic            f_valid;
	logic            f_ready;
	lbof_pkg::item_t f_item;

	// queue to back
	logic            b_valid;
	logic            b_ready;
	lbof_pkg::item_t b_item;

	// front: separator and space detection, class remap, one register stage
	lbof_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_point  (code_point),
		.break_class (break_class),
		.end_of_text (end_of_text),
		.item_valid  (f_valid),
		.item_ready  (f_ready),
		.item        (f_item)
	);

	// short queue so front and back can stall on their own
	lbof_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_item  (b_item)
	);

	// back: line state, pair lookup and the output register
	lbof_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (b_valid),
		.item_ready   (b_ready),
		.item         (b_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.break_before (break_before),
		.break_after  (break_after)
	);

endmodule
